[rtl/mbsd_pkg.sv]
// Package: shared constants, codes and control types of the beam search decoder.
`timescale 1ns / 1ps
package mbsd_pkg;

   localparam int SLOTS   = 12;
   localparam int LEN_W   = 4;
   localparam int WORD_W  = 6;
   localparam int PROB_W  = 16;
   localparam int SCORE_W = 32;
   localparam int POS_W   = 4;
   localparam int CFG_W   = 7;

   localparam logic [CFG_W-1:0]   VOCAB_RESET = 7'd64;
   localparam logic [PROB_W-1:0]  PROB_ONE    = 16'h8000;
   localparam logic [SCORE_W-1:0] SCORE_ONE   = 32'h8000_0000;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_RUN  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_BEAM,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic tbl_we;
      logic init;
      logic issue;
      logic issue_ext;
      logic commit;
      logic emit_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic             pipe_busy;
      logic             next_all_ended;
      logic             out_free;
      logic [LEN_W-1:0] emit_len;
   } stat_type;

endpackage

[rtl/mbsd_ifs.sv]
// Interfaces: request and response channels of the beam search decoder.
`timescale 1ns / 1ps
interface mbsd_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  opcode;
   logic [5:0]  from_word;
   logic [5:0]  to_word;
   logic [15:0] link_prob;

   modport source (output valid, opcode, from_word, to_word, link_prob, input ready);
   modport sink   (input valid, opcode, from_word, to_word, link_prob, output ready);
endinterface

interface mbsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  word_index;
   logic [3:0]  position;
   logic [31:0] path_score;
   logic [0:0]  last_word;

   modport source (output valid, word_index, position, path_score, last_word, input ready);
   modport sink   (input valid, word_index, position, path_score, last_word, output ready);
endinterface

[rtl/mbsd_dp.sv]
// Datapath: transition table, beam storage, score pipeline, top-k insertion, output register.
`timescale 1ns / 1ps
module mbsd_dp #(
   parameter int VOCAB_MAX = 64,
   parameter int BEAM      = 2,
   localparam int WW  = $clog2(VOCAB_MAX),
   localparam int BIW = (BEAM > 1) ? $clog2(BEAM) : 1,
   localparam int BCW = $clog2(BEAM + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbsd_pkg::cmd_type       cmd,
   input  logic [BIW-1:0]          beam_sel,
   input  logic [WW-1:0]           word_sel,
   input  logic [3:0]              emit_pos,
   input  logic [5:0]              from_word,
   input  logic [5:0]              to_word,
   input  logic [15:0]             link_prob,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [5:0]              rsp_word_index,
   output logic [3:0]              rsp_position,
   output logic [31:0]             rsp_path_score,
   output logic                    rsp_last_word,
   output mbsd_pkg::stat_type      status,
   output logic [BCW-1:0]          beam_count,
   output logic [BEAM-1:0]         last_end,
   output logic [BEAM-1:0]         full
);
   import mbsd_pkg::*;

   localparam int DEPTH = VOCAB_MAX * VOCAB_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // table memory
   logic [PROB_W-1:0] table_mem [DEPTH];
   logic [PROB_W-1:0] mem_q_ff;
   logic [PROB_W-1:0] prob_sat;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic              wr_ok;

   // current and next beams
   logic [WW-1:0]      bw_ff [BEAM][SLOTS];
   logic [WW-1:0]      bw_in [BEAM][SLOTS];
   logic [SCORE_W-1:0] bs_ff [BEAM];
   logic [SCORE_W-1:0] bs_in [BEAM];
   logic [LEN_W-1:0]   bl_ff [BEAM];
   logic [LEN_W-1:0]   bl_in [BEAM];
   logic [BCW-1:0]     count_ff, count_in;
   logic [WW-1:0]      nw_ff [BEAM][SLOTS];
   logic [WW-1:0]      nw_in [BEAM][SLOTS];
   logic [SCORE_W-1:0] ns_ff [BEAM];
   logic [SCORE_W-1:0] ns_in [BEAM];
   logic [LEN_W-1:0]   nl_ff [BEAM];
   logic [LEN_W-1:0]   nl_in [BEAM];
   logic [BCW-1:0]     fill_ff, fill_in;
   logic [WW-1:0]      lastw [BEAM];

   // pipeline stages
   logic               v1_ff, ext1_ff, v2_ff, ext2_ff;
   logic [BIW-1:0]     src1_ff, src2_ff;
   logic [WW-1:0]      w1_ff, w2_ff;
   logic [SCORE_W-1:0] sc2_ff, sc1, score1;
   logic [47:0]        prod1;
   logic               keep1;

   // insertion
   logic [BCW-1:0]     pos, lim;
   logic               ins;
   logic [WW-1:0]      cand_w [SLOTS];
   logic [LEN_W-1:0]   cand_l;
   logic               all_end;

   // output register
   logic               rv_ff;
   logic [5:0]         rw_ff;
   logic [3:0]         rp_ff;
   logic [31:0]        rs_ff;
   logic               rl_ff;
   logic [LEN_W-1:0]   emit_len;
   logic [WW-1:0]      emit_word;

   // write path saturates probabilities above one
   assign prob_sat = (link_prob > PROB_ONE) ? PROB_ONE : link_prob;
   assign wr_ok    = (32'(from_word) < VOCAB_MAX) && (32'(to_word) < VOCAB_MAX);
   assign wr_addr  = AW'(32'(from_word) * VOCAB_MAX + 32'(to_word));
   assign rd_addr  = AW'(32'(lastw[beam_sel]) * VOCAB_MAX + 32'(word_sel));

   always_ff @(posedge clock) begin
      if (cmd.tbl_we && wr_ok) begin
         table_mem[wr_addr] <= prob_sat;
      end
      if (cmd.issue) begin
         mem_q_ff <= table_mem[rd_addr];
      end
   end

   // last word of each beam, end and full flags
   always_comb begin
      for (int b = 0; b < BEAM; b++) begin
         if (bl_ff[b] == '0 || 32'(bl_ff[b]) > SLOTS) begin
            lastw[b] = '0;
         end else begin
            lastw[b] = bw_ff[b][bl_ff[b] - 1'b1];
         end
         last_end[b] = (lastw[b] == '0);
         full[b]     = (32'(bl_ff[b]) >= SLOTS);
      end
   end

   // stage 1: scale an extended candidate's score by the table entry; carried beams keep theirs
   assign sc1    = bs_ff[src1_ff];
   assign prod1  = 48'(sc1) * 48'(mem_q_ff);
   assign score1 = ext1_ff ? prod1[46:15] : sc1;
   assign keep1  = ext1_ff ? (mem_q_ff != '0) : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff && keep1;
      end
      src1_ff <= beam_sel;
      w1_ff   <= word_sel;
      ext1_ff <= cmd.issue_ext;
      src2_ff <= src1_ff;
      w2_ff   <= w1_ff;
      ext2_ff <= ext1_ff;
      sc2_ff  <= score1;
   end

   // stage 2: rank the candidate among the kept ones, earlier wins ties
   always_comb begin
      pos = '0;
      for (int k = 0; k < BEAM; k++) begin
         if (32'(k) < 32'(fill_ff) && ns_ff[k] >= sc2_ff) begin
            pos = pos + 1'b1;
         end
      end
      ins = v2_ff && (32'(pos) < BEAM);
      lim = (32'(fill_ff) < BEAM) ? fill_ff : BCW'(BEAM - 1);
      for (int j = 0; j < SLOTS; j++) begin
         cand_w[j] = bw_ff[src2_ff][j];
         if (ext2_ff && 32'(j) == 32'(bl_ff[src2_ff])) begin
            cand_w[j] = w2_ff;
         end
      end
      cand_l = bl_ff[src2_ff];
      if (ext2_ff && 32'(bl_ff[src2_ff]) < SLOTS) begin
         cand_l = bl_ff[src2_ff] + 1'b1;
      end
   end

   // next-beam list update
   always_comb begin
      nw_in   = nw_ff;
      ns_in   = ns_ff;
      nl_in   = nl_ff;
      fill_in = fill_ff;
      if (cmd.init || cmd.commit) begin
         fill_in = '0;
      end else if (ins) begin
         for (int k = 1; k < BEAM; k++) begin
            if (32'(k) > 32'(pos) && 32'(k) <= 32'(lim)) begin
               nw_in[k] = nw_ff[k-1];
               ns_in[k] = ns_ff[k-1];
               nl_in[k] = nl_ff[k-1];
            end
         end
         nw_in[BIW'(pos)] = cand_w;
         ns_in[BIW'(pos)] = sc2_ff;
         nl_in[BIW'(pos)] = cand_l;
         if (32'(fill_ff) < BEAM) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // current beams: start sentence or take over the kept candidates
   always_comb begin
      bw_in    = bw_ff;
      bs_in    = bs_ff;
      bl_in    = bl_ff;
      count_in = count_ff;
      if (cmd.init) begin
         bw_in[0][0] = WW'(1);
         bl_in[0]    = LEN_W'(1);
         bs_in[0]    = SCORE_ONE;
         count_in    = BCW'(1);
      end else if (cmd.commit) begin
         for (int i = 0; i < BEAM; i++) begin
            if (32'(i) < 32'(fill_ff)) begin
               bw_in[i] = nw_ff[i];
               bs_in[i] = ns_ff[i];
               bl_in[i] = nl_ff[i];
            end
         end
         count_in = fill_ff;
      end
   end

   // whether every kept candidate has ended
   always_comb begin
      all_end = 1'b1;
      for (int i = 0; i < BEAM; i++) begin
         if (32'(i) < 32'(fill_ff) && nl_ff[i] != '0 && 32'(nl_ff[i]) <= SLOTS) begin
            if (nw_ff[i][nl_ff[i] - 1'b1] != '0) begin
               all_end = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
      bw_ff <= bw_in;
      bs_ff <= bs_in;
      bl_ff <= bl_in;
      nw_ff <= nw_in;
      ns_ff <= ns_in;
      nl_ff <= nl_in;
   end

   // sentence readout, end word appended when missing and room is left
   assign emit_len  = (32'(bl_ff[0]) < SLOTS && lastw[0] != '0) ? bl_ff[0] + 1'b1 : bl_ff[0];
   assign emit_word = (emit_pos < bl_ff[0] && 32'(emit_pos) < SLOTS) ? bw_ff[0][emit_pos] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rv_ff <= 1'b1;
      end else if (rsp_ready) begin
         rv_ff <= 1'b0;
      end
      if (cmd.emit_load) begin
         rw_ff <= 6'(emit_word);
         rp_ff <= emit_pos;
         rs_ff <= bs_ff[0];
         rl_ff <= (emit_pos == emit_len - 1'b1);
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_word_index = rw_ff;
   assign rsp_position   = rp_ff;
   assign rsp_path_score = rs_ff;
   assign rsp_last_word  = rl_ff;
   assign beam_count     = count_ff;

   assign status.pipe_busy      = v1_ff || v2_ff;
   assign status.next_all_ended = all_end;
   assign status.out_free       = !rv_ff || rsp_ready;
   assign status.emit_len       = emit_len;

endmodule

[rtl/mbsd_ctrl.sv]
// Controller: sequences table loads, search rounds, candidate scan and sentence readout.
`timescale 1ns / 1ps
module mbsd_ctrl #(
   parameter int VOCAB_MAX  = 64,
   parameter int BEAM       = 2,
   parameter int MAX_ROUNDS = 10,
   localparam int WW  = $clog2(VOCAB_MAX),
   localparam int BIW = (BEAM > 1) ? $clog2(BEAM) : 1,
   localparam int BCW = $clog2(BEAM + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic                 csr_we,
   input  logic [6:0]           csr_wdata,
   input  mbsd_pkg::stat_type   status,
   input  logic [BCW-1:0]       beam_count,
   input  logic [BEAM-1:0]      last_end,
   input  logic [BEAM-1:0]      full,
   output mbsd_pkg::cmd_type    cmd,
   output logic [BIW-1:0]       beam_sel,
   output logic [WW-1:0]        word_sel,
   output logic [3:0]           emit_pos
);
   import mbsd_pkg::*;

   localparam int VW = $clog2(VOCAB_MAX + 1);
   localparam int RW = $clog2(MAX_ROUNDS + 1);

   state_type        state_ff, state_in;
   logic [BCW-1:0]   i_ff, i_in;
   logic [WW-1:0]    w_ff, w_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [3:0]       k_ff, k_in;
   logic [CFG_W-1:0] csr_ff;
   logic [VW-1:0]    vocab_eff;
   logic             w_last;
   logic [BIW-1:0]   idx;

   // vocabulary register, clamped to the table size
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= VOCAB_RESET;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   assign vocab_eff = (32'(csr_ff) > VOCAB_MAX) ? VW'(VOCAB_MAX) : VW'(csr_ff);
   assign w_last    = (32'(w_ff) + 1) == 32'(vocab_eff);
   assign idx       = i_ff[BIW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         w_ff     <= '0;
         r_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         w_ff     <= w_in;
         r_ff     <= r_in;
         k_ff     <= k_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      w_in      = w_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.tbl_we = 1'b1;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            r_in     = '0;
            i_in     = '0;
            state_in = ST_BEAM;
         end
         ST_BEAM: begin
            if (i_ff >= beam_count) begin
               state_in = ST_DRAIN;
            end else if (last_end[idx]) begin
               // ended sentence is carried over unchanged
               cmd.issue = 1'b1;
               i_in      = i_ff + 1'b1;
            end else if (full[idx] || vocab_eff == '0) begin
               i_in = i_ff + 1'b1;
            end else begin
               w_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue     = 1'b1;
            cmd.issue_ext = 1'b1;
            if (w_last) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_BEAM;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            r_in       = r_ff + 1'b1;
            if (status.next_all_ended || (32'(r_ff) + 1) == MAX_ROUNDS) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end else begin
               i_in     = '0;
               state_in = ST_BEAM;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (k_ff == status.emit_len - 1'b1) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign beam_sel = idx;
   assign word_sel = w_ff;
   assign emit_pos = k_ff;

endmodule

[rtl/markov_beam_search_decoder.sv]
// Top level of the beam search decoder over a word-to-word transition table.
//
// Usage: the req_bus channel carries transactions. A load (opcode 0) writes one
// UQ1.15 table entry and returns nothing. A run (opcode 1) searches
// with BEAM sentences from the start word and returns the best sentence on rsp_bus,
// one transaction per word, the end word appended when missing if room is left,
// last_word on the final one. csr_we/csr_wdata set the vocabulary size (reset 64).
// A run scans, per round, every word in use for each kept beam that has not ended
// or filled up, then drains the score pipeline and commits, for at most MAX_ROUNDS
// rounds, then emits one word per transaction. The rate is set by the single table
// read port, which delivers one candidate per cycle during a scan.
// Score pipeline: table read, multiply, insertion (3 stages).
// Reset clears the control state and sets the vocabulary register to 64; table
// contents are undefined until written. A stalled receiver holds the output
// register and the readout waits; the next request is taken once the final word
// is registered.
`timescale 1ns / 1ps
module markov_beam_search_decoder #(
   parameter int VOCAB_MAX  = 64,
   parameter int BEAM       = 2,
   parameter int MAX_ROUNDS = 10
) (
   input  logic       clock,
   input  logic       reset,
   mbsd_req_if.sink   req_bus,
   mbsd_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);
   import mbsd_pkg::*;

   localparam int WW  = $clog2(VOCAB_MAX);
   localparam int BIW = (BEAM > 1) ? $clog2(BEAM) : 1;
   localparam int BCW = $clog2(BEAM + 1);

   cmd_type         cmd;
   stat_type        status;
   logic [BIW-1:0]  beam_sel;
   logic [WW-1:0]   word_sel;
   logic [3:0]      emit_pos;
   logic [BCW-1:0]  beam_count;
   logic [BEAM-1:0] last_end;
   logic [BEAM-1:0] full;

   // sequencer
   mbsd_ctrl #(
      .VOCAB_MAX  (VOCAB_MAX),
      .BEAM       (BEAM),
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_opcode (req_bus.opcode[0]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .beam_count (beam_count),
      .last_end   (last_end),
      .full       (full),
      .cmd        (cmd),
      .beam_sel   (beam_sel),
      .word_sel   (word_sel),
      .emit_pos   (emit_pos)
   );

   // table, beams and output register
   mbsd_dp #(
      .VOCAB_MAX (VOCAB_MAX),
      .BEAM      (BEAM)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .beam_sel       (beam_sel),
      .word_sel       (word_sel),
      .emit_pos       (emit_pos),
      .from_word      (req_bus.from_word),
      .to_word        (req_bus.to_word),
      .link_prob      (req_bus.link_prob),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_word_index (rsp_bus.word_index),
      .rsp_position   (rsp_bus.position),
      .rsp_path_score (rsp_bus.path_score),
      .rsp_last_word  (rsp_bus.last_word[0]),
      .status         (status),
      .beam_count     (beam_count),
      .last_end       (last_end),
      .full           (full)
   );

endmodule
